// ===== hdl/set_assoc_lru_cache_sim_defines.svh =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_defines
// Assertion macros shared by the cache simulator RTL.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SALC_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SALC_CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Types, codes and helpers of the set-associative LRU cache simulator.
// ----------------------------------------------------------------------------
package salc_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCAN,
        S_UPDATE
    } t_state;

    typedef logic [2:0] t_age;

    localparam t_age AGE_MAX = 3'd7;

    localparam logic [1:0] REQ_MODIFY = 2'd2;

    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_WAYS       = 2'd1;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

    localparam logic [2:0] SET_BITS_RST   = 3'd4;
    localparam logic [3:0] WAYS_RST       = 4'd1;
    localparam logic [4:0] BLOCK_BITS_RST = 5'd4;

    typedef struct packed {
        logic init;
        logic scan;
        logic commit;
        logic clear;
    } t_lru_ctl;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [1:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {31'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ===== hdl/salc_tag_unit.sv =====
// ----------------------------------------------------------------------------
// salc_tag_unit
// Tag memory with one registered read port and the shared tag comparator.
// ----------------------------------------------------------------------------
module salc_tag_unit #(
    parameter int IDX_W = 9,
    parameter int TAG_W = 64
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  logic [TAG_W-1:0] i_wr_tag,
    input  logic [TAG_W-1:0] i_cmp_tag,
    output logic             o_match
);

    localparam int DEPTH = 1 << IDX_W;

    logic [TAG_W-1:0] r_mem [DEPTH];
    logic [TAG_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_idx] <= i_wr_tag;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_idx];
        end
    end

    assign o_match = (r_q == i_cmp_tag);

endmodule

// ===== hdl/salc_lru_unit.sv =====
// ----------------------------------------------------------------------------
// salc_lru_unit
// Per-set valid/age store, way scan tracking and LRU row update.
// ----------------------------------------------------------------------------
module salc_lru_unit import salc_pkg::*; #(
    parameter int SET_W    = 6,
    parameter int ROWS     = 64,
    parameter int MAX_WAYS = 8,
    parameter int WAY_W    = 3,
    parameter int NW_W     = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_lru_ctl         i_ctl,
    input  logic [SET_W-1:0] i_row,
    input  logic [WAY_W-1:0] i_way,
    input  logic [NW_W-1:0]  i_nw,
    input  logic             i_match,
    output logic             o_hit,
    output logic             o_evict,
    output logic [WAY_W-1:0] o_fill_way
);

    logic [MAX_WAYS-1:0]       r_mem_v [ROWS];
    t_age [MAX_WAYS-1:0]       r_mem_a [ROWS];
    logic [MAX_WAYS-1:0]       r_row_v;
    t_age [MAX_WAYS-1:0]       r_row_a;

    logic                      r_hit;
    logic [WAY_W-1:0]          r_hit_way;
    logic                      r_found;
    logic [WAY_W-1:0]          r_inv_way;
    t_age                      r_oldest;
    logic [WAY_W-1:0]          r_old_way;

    logic [MAX_WAYS-1:0]       n_v;
    t_age [MAX_WAYS-1:0]       n_a;
    logic [WAY_W-1:0]          victim;
    logic [WAY_W-1:0]          sel;
    logic [3:0]                limit;
    logic                      cur_v;
    t_age                      cur_a;

    assign cur_v  = r_row_v[i_way];
    assign cur_a  = r_row_a[i_way];
    assign victim = r_found ? r_inv_way : r_old_way;
    assign sel    = r_hit ? r_hit_way : victim;

    always_comb begin
        if (r_hit) begin
            limit = {1'b0, r_row_a[r_hit_way]};
        end else if (r_found) begin
            limit = 4'd8;
        end else begin
            limit = {1'b0, r_oldest};
        end
        n_v = r_row_v;
        n_a = r_row_a;
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (NW_W'(i) < i_nw && WAY_W'(i) != sel && r_row_v[i] &&
                {1'b0, r_row_a[i]} < limit && r_row_a[i] < AGE_MAX) begin
                n_a[i] = r_row_a[i] + 3'd1;
            end
        end
        n_a[sel] = '0;
        n_v[sel] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_mem_v[i_row] <= '0;
            r_mem_a[i_row] <= '0;
        end else if (i_ctl.commit) begin
            r_mem_v[i_row] <= n_v;
            r_mem_a[i_row] <= n_a;
        end
        if (i_ctl.init) begin
            r_row_v <= r_mem_v[i_row];
            r_row_a <= r_mem_a[i_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit     <= 1'b0;
            r_hit_way <= '0;
            r_found   <= 1'b0;
            r_inv_way <= '0;
            r_oldest  <= '0;
            r_old_way <= '0;
        end else if (i_ctl.init) begin
            r_hit     <= 1'b0;
            r_hit_way <= '0;
            r_found   <= 1'b0;
            r_inv_way <= '0;
            r_oldest  <= '0;
            r_old_way <= '0;
        end else if (i_ctl.scan) begin
            if (!r_hit && cur_v && i_match) begin
                r_hit     <= 1'b1;
                r_hit_way <= i_way;
            end
            if (!r_found && !cur_v) begin
                r_found   <= 1'b1;
                r_inv_way <= i_way;
            end
            if (cur_a > r_oldest) begin
                r_oldest  <= cur_a;
                r_old_way <= i_way;
            end
        end
    end

    assign o_hit      = r_hit;
    assign o_evict    = !r_hit && !r_found;
    assign o_fill_way = victim;

endmodule

// ===== hdl/set_assoc_lru_cache_sim.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim
// Set-associative cache simulator with LRU replacement and saturating totals.
// ----------------------------------------------------------------------------
// An access is taken when start is high and busy is low. The set is read in
// S_READ; in S_SCAN the single tag read port and comparator check one way per
// cycle over the configured ways (clamped to 1..MAX_WAYS); the set is written
// back in S_UPDATE. The result shows for one cycle with o_valid and cannot be
// held off; a new access can be taken in that same cycle. After reset and
// after a register write while idle or clearing, busy stays high while the
// valid/age store is cleared one set a cycle, 2**MAX_SET_BITS sets in all.
`include "set_assoc_lru_cache_sim_defines.svh"

module set_assoc_lru_cache_sim import salc_pkg::*; #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8,
    parameter int ADDR_WIDTH   = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_req_type,
    input  logic [ADDR_WIDTH-1:0] i_address,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [4:0]            i_cfg_data,
    output logic                  o_valid,
    output logic                  o_hit,
    output logic                  o_miss,
    output logic                  o_evicted,
    output logic [31:0]           o_hit_total,
    output logic [31:0]           o_miss_total,
    output logic [31:0]           o_evict_total
);

    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ROWS  = 1 << MAX_SET_BITS;
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W  = $clog2(MAX_WAYS + 1);
    localparam int IDX_W = SET_W + WAY_W;

    t_state                r_state, n_state;
    logic [SET_W-1:0]      r_clr_idx;
    logic [SET_W-1:0]      r_set;
    logic [ADDR_WIDTH-1:0] r_tag;
    logic [1:0]            r_kind;
    logic [NW_W-1:0]       r_nw;
    logic [WAY_W-1:0]      r_way;
    logic [2:0]            r_set_bits;
    logic [3:0]            r_ways;
    logic [4:0]            r_block_bits;
    logic [31:0]           r_hit_cnt, r_miss_cnt, r_evict_cnt;
    logic                  r_valid, r_hit, r_miss, r_evicted;

    t_lru_ctl              ctl;
    logic                  accept;
    logic                  cfg_wr;
    logic                  last_way;
    logic [3:0]            sb;
    logic [NW_W-1:0]       nw;
    logic [5:0]            tag_sh;
    logic [SET_W:0]        set_mask;
    logic [ADDR_WIDTH-1:0] addr_sh;
    logic [SET_W-1:0]      set_idx;
    logic [WAY_W-1:0]      rd_way;
    logic [SET_W-1:0]      row_sel;
    logic                  tag_match;
    logic                  lru_hit, lru_evict;
    logic [WAY_W-1:0]      fill_way;
    logic [1:0]            hit_inc;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign cfg_wr = i_cfg_we && (i_cfg_idx == CFG_SET_BITS || i_cfg_idx == CFG_WAYS ||
                                 i_cfg_idx == CFG_BLOCK_BITS);

    // address decode for the incoming access
    always_comb begin
        sb = (int'(r_set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, r_set_bits};
        if (r_ways == 4'd0) begin
            nw = NW_W'(1);
        end else if (int'(r_ways) > MAX_WAYS) begin
            nw = NW_W'(MAX_WAYS);
        end else begin
            nw = NW_W'(r_ways);
        end
        tag_sh   = {1'b0, r_block_bits} + {2'b0, sb};
        set_mask = ({{SET_W{1'b0}}, 1'b1} << sb) - 1'b1;
        addr_sh  = i_address >> r_block_bits;
        set_idx  = addr_sh[SET_W-1:0] & set_mask[SET_W-1:0];
    end

    assign last_way = (r_way == WAY_W'(r_nw - 1'b1));
    assign rd_way   = (r_state == S_READ) ? '0 : r_way + 1'b1;
    assign row_sel  = (r_state == S_CLEAR) ? r_clr_idx : r_set;

    always_comb begin
        n_state    = r_state;
        ctl        = '0;
        unique case (r_state)
            S_CLEAR: begin
                ctl.clear = 1'b1;
                if (r_clr_idx == SET_W'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                ctl.init = 1'b1;
                n_state  = S_SCAN;
            end
            S_SCAN: begin
                ctl.scan = 1'b1;
                if (last_way) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                ctl.commit = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
        if (cfg_wr && (r_state == S_IDLE || r_state == S_CLEAR)) begin
            n_state = S_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_way     <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr || r_state != S_CLEAR) begin
                r_clr_idx <= '0;
            end else begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (r_state == S_READ) begin
                r_way <= '0;
            end else if (r_state == S_SCAN) begin
                r_way <= r_way + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set  <= set_idx;
            r_tag  <= i_address >> tag_sh;
            r_kind <= i_req_type;
            r_nw   <= nw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= SET_BITS_RST;
            r_ways       <= WAYS_RST;
            r_block_bits <= BLOCK_BITS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SET_BITS:   r_set_bits   <= i_cfg_data[2:0];
                CFG_WAYS:       r_ways       <= i_cfg_data[3:0];
                CFG_BLOCK_BITS: r_block_bits <= i_cfg_data;
                default: ;
            endcase
        end
    end

    salc_tag_unit #(
        .IDX_W (IDX_W),
        .TAG_W (ADDR_WIDTH)
    ) u_tag (
        .i_clk     (i_clk),
        .i_rd_en   (r_state == S_READ || r_state == S_SCAN),
        .i_rd_idx  ({r_set, rd_way}),
        .i_we      (ctl.commit && !lru_hit),
        .i_wr_idx  ({r_set, fill_way}),
        .i_wr_tag  (r_tag),
        .i_cmp_tag (r_tag),
        .o_match   (tag_match)
    );

    salc_lru_unit #(
        .SET_W    (SET_W),
        .ROWS     (ROWS),
        .MAX_WAYS (MAX_WAYS),
        .WAY_W    (WAY_W),
        .NW_W     (NW_W)
    ) u_lru (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_row      (row_sel),
        .i_way      (r_way),
        .i_nw       (r_nw),
        .i_match    (tag_match),
        .o_hit      (lru_hit),
        .o_evict    (lru_evict),
        .o_fill_way (fill_way)
    );

    // modify adds one hit for its store on top of the load's outcome
    always_comb begin
        if (r_kind == REQ_MODIFY) begin
            hit_inc = lru_hit ? 2'd2 : 2'd1;
        end else begin
            hit_inc = lru_hit ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= ctl.commit;
            if (ctl.commit) begin
                r_hit_cnt   <= sat_add(r_hit_cnt, hit_inc);
                r_miss_cnt  <= sat_add(r_miss_cnt, {1'b0, !lru_hit});
                r_evict_cnt <= sat_add(r_evict_cnt, {1'b0, lru_evict});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.commit) begin
            r_hit     <= lru_hit;
            r_miss    <= !lru_hit;
            r_evicted <= lru_evict;
        end
    end

    assign o_valid       = r_valid;
    assign o_hit         = r_hit;
    assign o_miss        = r_miss;
    assign o_evicted     = r_evicted;
    assign o_hit_total   = r_hit_cnt;
    assign o_miss_total  = r_miss_cnt;
    assign o_evict_total = r_evict_cnt;

    `SALC_CHK_NOW(a_result_idle, o_valid, !busy, "result while sequencer busy")
    `SALC_CHK_NOW(a_flags_ok, o_valid, (o_hit != o_miss) && (!o_evicted || o_miss),
                  "inconsistent hit/miss/evict flags")
    `SALC_CHK_NEXT(a_accept_busy, accept, busy, "accepted transfer did not start")
    `SALC_CHK_NEXT(a_cfg_clear, cfg_wr && !busy, r_state == S_CLEAR,
                   "register write did not start clear pass")

endmodule

// ===== bench/set_assoc_lru_cache_sim_tb.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim_tb
// Self-checking bench for the set-associative LRU cache simulator. A scoreboard
// class tracks tags, valid bits, LRU ages and totals, predicts the flags and
// totals of each accepted access, and compares them with every result strobe.
// Directed accesses cover hits, misses, evictions, every access kind and the
// register corner cases. Random phases then run under many cache geometries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module set_assoc_lru_cache_sim_tb import salc_pkg::*; ();

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_WIDTH   = 64;
    localparam int NUM_LINES    = (1 << MAX_SET_BITS) * MAX_WAYS;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_STORE = 2'd1;
    localparam logic [1:0] REQ_ODD   = 2'd3;
    localparam logic [1:0] CFG_NONE  = 2'd3;

    localparam int PHASE_ITEMS = 135;
    localparam int IDLE_PCT    = 32;

    typedef struct {
        logic        hit;
        logic        miss;
        logic        evicted;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
    } t_access_result;

    class cache_scoreboard;
        logic [63:0]    tag_mem [NUM_LINES];
        bit             line_live [NUM_LINES];
        bit [2:0]       line_age [NUM_LINES];
        bit [31:0]      hit_cnt;
        bit [31:0]      miss_cnt;
        bit [31:0]      evict_cnt;
        bit [2:0]       set_bits;
        bit [3:0]       ways;
        bit [4:0]       block_bits;
        t_access_result result_q[$];
        int             errors;

        function new();
            set_bits   = SET_BITS_RST;
            ways       = WAYS_RST;
            block_bits = BLOCK_BITS_RST;
            hit_cnt    = 0;
            miss_cnt   = 0;
            evict_cnt  = 0;
            errors     = 0;
            foreach (tag_mem[i]) tag_mem[i] = '0;
            flush();
        endfunction

        function void flush();
            foreach (line_live[i]) begin
                line_live[i] = 1'b0;
                line_age[i]  = '0;
            end
        endfunction

        function int eff_set_bits();
            return (set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits);
        endfunction

        function int eff_ways();
            if (ways == 0) return 1;
            return (ways > MAX_WAYS) ? MAX_WAYS : int'(ways);
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        function bit [31:0] sat_inc(bit [31:0] a, int b);
            bit [32:0] s;
            s = {1'b0, a} + 33'(b);
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void configure(logic [1:0] idx, logic [4:0] data);
            case (idx)
                CFG_SET_BITS:   set_bits   = data[2:0];
                CFG_WAYS:       ways       = data[3:0];
                CFG_BLOCK_BITS: block_bits = data;
                default:        return;
            endcase
            flush();
        endfunction

        // other live lines younger than limit age by one; touched way goes to 0
        function void age_lines(int base, int nw, int way, int limit);
            for (int i = 0; i < nw; i++) begin
                if (i != way && line_live[base + i] && line_age[base + i] < limit &&
                    line_age[base + i] < AGE_MAX)
                    line_age[base + i]++;
            end
            line_age[base + way] = '0;
        endfunction

        function void note(logic [1:0] kind, logic [63:0] addr);
            int             sbits;
            int             nw;
            int             bb;
            int             base;
            int             way;
            int             oldest;
            bit             found;
            logic [63:0]    set_idx;
            logic [63:0]    tag;
            t_access_result r;
            sbits   = eff_set_bits();
            nw      = eff_ways();
            bb      = block_bits;
            set_idx = (addr >> bb) & ((64'd1 << sbits) - 64'd1);
            tag     = addr >> (bb + sbits);
            base    = int'(set_idx) * MAX_WAYS;
            r.hit   = 1'b0;
            r.miss  = 1'b0;
            r.evicted = 1'b0;
            way     = 0;
            for (int i = 0; i < nw; i++) begin
                if (line_live[base + i] && tag_mem[base + i] == tag) begin
                    r.hit = 1'b1;
                    way   = i;
                    break;
                end
            end
            if (r.hit) begin
                age_lines(base, nw, way, line_age[base + way]);
                hit_cnt = sat_inc(hit_cnt, (kind == REQ_MODIFY) ? 2 : 1);
            end else begin
                r.miss   = 1'b1;
                miss_cnt = sat_inc(miss_cnt, 1);
                found    = 1'b0;
                for (int i = 0; i < nw; i++) begin
                    if (!line_live[base + i]) begin
                        way   = i;
                        found = 1'b1;
                        break;
                    end
                end
                if (found) begin
                    line_live[base + way] = 1'b1;
                    tag_mem[base + way]   = tag;
                    age_lines(base, nw, way, AGE_MAX + 1);
                end else begin
                    oldest = 0;
                    way    = 0;
                    for (int i = 0; i < nw; i++) begin
                        if (line_age[base + i] > oldest) begin
                            oldest = line_age[base + i];
                            way    = i;
                        end
                    end
                    r.evicted = 1'b1;
                    evict_cnt = sat_inc(evict_cnt, 1);
                    tag_mem[base + way] = tag;
                    age_lines(base, nw, way, oldest);
                end
                if (kind == REQ_MODIFY) hit_cnt = sat_inc(hit_cnt, 1);
            end
            r.hit_total   = hit_cnt;
            r.miss_total  = miss_cnt;
            r.evict_total = evict_cnt;
            result_q.push_back(r);
        endfunction

        function void diff(string name, logic [31:0] e, logic [31:0] a);
            if (a !== e) begin
                $display("%0t ERROR %s expected %0h actual %0h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check(t_access_result a);
            t_access_result e;
            if (result_q.size() == 0) begin
                $display("%0t ERROR result with none expected: hit %0b miss %0b evicted %0b",
                         $time, a.hit, a.miss, a.evicted);
                errors++;
                return;
            end
            e = result_q.pop_front();
            diff("hit",         e.hit,         a.hit);
            diff("miss",        e.miss,        a.miss);
            diff("evicted",     e.evicted,     a.evicted);
            diff("hit_total",   e.hit_total,   a.hit_total);
            diff("miss_total",  e.miss_total,  a.miss_total);
            diff("evict_total", e.evict_total, a.evict_total);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_req_type;
    logic [63:0] i_address;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [4:0]  i_cfg_data;
    logic        o_valid;
    logic        o_hit;
    logic        o_miss;
    logic        o_evicted;
    logic [31:0] o_hit_total;
    logic [31:0] o_miss_total;
    logic [31:0] o_evict_total;

    cache_scoreboard sb = new();
    bit              idle_on = 1'b1;

    set_assoc_lru_cache_sim #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_address     (i_address),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_miss        (o_miss),
        .o_evicted     (o_evicted),
        .o_hit_total   (o_hit_total),
        .o_miss_total  (o_miss_total),
        .o_evict_total (o_evict_total)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_access_result a;
        if (i_rst_n && o_valid) begin
            a.hit         = o_hit;
            a.miss        = o_miss;
            a.evicted     = o_evicted;
            a.hit_total   = o_hit_total;
            a.miss_total  = o_miss_total;
            a.evict_total = o_evict_total;
            sb.check(a);
        end
    end

    // start drops after the transfer so an idle block does not take it twice
    task automatic send_access(logic [1:0] kind, logic [63:0] addr);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_req_type <= kind;
        i_address  <= addr;
        do @(posedge i_clk); while (busy);
        sb.note(kind, addr);
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] data);
        wait_drained();
        repeat (MAX_WAYS + 6) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        start      <= 1'b0;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.configure(idx, data);
    endtask

    task automatic set_geometry(logic [4:0] sbits, logic [4:0] nways, logic [4:0] bbits);
        write_reg(CFG_SET_BITS, sbits);
        write_reg(CFG_WAYS, nways);
        write_reg(CFG_BLOCK_BITS, bbits);
    endtask

    // mostly a few tags over two sets so hits and evictions are common
    task automatic run_phase(int count);
        logic [63:0] tag_pool [MAX_WAYS + 2];
        logic [63:0] set_pool [2];
        logic [63:0] addr;
        int          sbits;
        int          bb;
        int          k;
        sbits = sb.eff_set_bits();
        bb    = sb.block_bits;
        foreach (tag_pool[i]) tag_pool[i] = {$urandom, $urandom};
        foreach (set_pool[i]) set_pool[i] = {$urandom, $urandom} & ((64'd1 << sbits) - 64'd1);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) wait_drained();
            if ($urandom_range(99) < 25) begin
                addr = {$urandom, $urandom};
            end else begin
                k    = $urandom_range(sb.eff_ways() + 1);
                addr = (tag_pool[k] << (bb + sbits)) | (set_pool[$urandom_range(1)] << bb) |
                       ({$urandom, $urandom} & ((64'd1 << bb) - 64'd1));
            end
            send_access(2'($urandom_range(3)), addr);
        end
    endtask

    initial begin
        logic [4:0] sb_list [10];
        logic [4:0] w_list  [10];
        logic [4:0] bb_list [10];
        sb_list    = '{5'd4, 5'd0, 5'd6, 5'd7, 5'd2, 5'd3, 5'd1, 5'd5, 5'd6, 5'd0};
        w_list     = '{5'd1, 5'd8, 5'd8, 5'd15, 5'd4, 5'd0, 5'd2, 5'd3, 5'd9, 5'd1};
        bb_list    = '{5'd4, 5'd0, 5'd20, 5'd31, 5'd3, 5'd5, 5'd1, 5'd12, 5'd7, 5'd20};
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req_type = '0;
        i_address  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: 16 sets, direct mapped, 16-byte lines
        send_access(REQ_LOAD,   64'h0);
        send_access(REQ_STORE,  64'h8);
        send_access(REQ_MODIFY, 64'hF);
        send_access(REQ_ODD,    64'h100);
        send_access(REQ_MODIFY, 64'h0);
        send_access(REQ_LOAD,   64'hFFFF_FFFF_FFFF_FFFF);
        send_access(REQ_STORE,  64'hFFFF_FFFF_FFFF_FFF0);
        send_access(REQ_MODIFY, 64'hFFFF_FFFF_FFFF_FF00);
        send_access(REQ_LOAD,   64'h8000_0000_0000_0000);
        send_access(REQ_ODD,    64'h8000_0000_0000_0007);
        // write to a missing register keeps the lines
        write_reg(CFG_NONE, 5'h1F);
        send_access(REQ_LOAD,   64'h8000_0000_0000_0000);

        // one set, two ways, byte lines: LRU order
        set_geometry(5'd0, 5'd2, 5'd0);
        send_access(REQ_LOAD,   64'h0);
        send_access(REQ_LOAD,   64'h1);
        send_access(REQ_LOAD,   64'h0);
        send_access(REQ_STORE,  64'h2);
        send_access(REQ_MODIFY, 64'h1);
        send_access(REQ_MODIFY, 64'h2);
        send_access(REQ_LOAD,   64'h0);
        send_access(REQ_ODD,    64'h1);
        send_access(REQ_LOAD,   64'hFFFF_FFFF_FFFF_FFFF);

        for (int p = 0; p < 14; p++) begin
            if (p < 10) set_geometry(sb_list[p], w_list[p], bb_list[p]);
            else set_geometry(5'($urandom_range(31)), 5'($urandom_range(31)),
                              5'($urandom_range(31)));
            idle_on = (p != 2);
            run_phase(PHASE_ITEMS);
        end
        idle_on = 1'b1;

        @(negedge i_clk);
        start <= 1'b0;
        wait_drained();
        repeat (MAX_WAYS + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
